// ----- rtl/core/jl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jl_pkg: shared types, constants and lookup functions of the Jack lexer
// Token kinds, lexer modes, character classes and the keyword table.
// ----------------------------------------------------------------------------
package jl_pkg;

  localparam int POS_BITS = 20;
  localparam int NUM_KW   = 21;

  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_SYMBOL  = 3'd1;
  localparam logic [2:0] KIND_STRING  = 3'd2;
  localparam logic [2:0] KIND_INTEGER = 3'd3;
  localparam logic [2:0] KIND_IDENT   = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;
  localparam logic [2:0] KIND_END     = 3'd6;

  localparam logic [4:0] NO_KEYWORD = 5'd21;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_EOF   = 8'hFF;

  typedef enum logic [7:0] {
    MODE_IDLE      = 8'b0000_0001,
    MODE_SLASH     = 8'b0000_0010,
    MODE_LINE      = 8'b0000_0100,
    MODE_BLOCK     = 8'b0000_1000,
    MODE_BLOCKSTAR = 8'b0001_0000,
    MODE_IDENT     = 8'b0010_0000,
    MODE_STRING    = 8'b0100_0000,
    MODE_INT       = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic [POS_BITS-1:0] start;
    logic [POS_BITS:0]   length;
    logic [7:0]          sym;
    logic [4:0]          kwn;
    logic                last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } scan_res_t;

  function automatic token_t make_tok(input logic [2:0] kind,
                                      input logic [POS_BITS-1:0] start,
                                      input logic [POS_BITS:0] length,
                                      input logic [7:0] sym,
                                      input logic [4:0] kwn);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = length;
    t.sym    = sym;
    t.kwn    = kwn;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    case (c) inside
      8'h20, 8'h09, 8'h0A, 8'h0D: is_space = 1'b1;
      default:                    is_space = 1'b0;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    case (c) inside
      "{", "}", "(", ")", "[", "]", ".", ",", ";",
      "+", "-", "*", "&", "|", "<", ">", "=", "~": is_symbol = 1'b1;
      default:                                   is_symbol = 1'b0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    unique case (k)
      5'd0:    kw_len = 4'd5;
      5'd1:    kw_len = 4'd11;
      5'd2:    kw_len = 4'd8;
      5'd3:    kw_len = 4'd6;
      5'd4:    kw_len = 4'd5;
      5'd5:    kw_len = 4'd6;
      5'd6:    kw_len = 4'd3;
      5'd7:    kw_len = 4'd3;
      5'd8:    kw_len = 4'd4;
      5'd9:    kw_len = 4'd7;
      5'd10:   kw_len = 4'd4;
      5'd11:   kw_len = 4'd4;
      5'd12:   kw_len = 4'd5;
      5'd13:   kw_len = 4'd4;
      5'd14:   kw_len = 4'd4;
      5'd15:   kw_len = 4'd3;
      5'd16:   kw_len = 4'd2;
      5'd17:   kw_len = 4'd2;
      5'd18:   kw_len = 4'd4;
      5'd19:   kw_len = 4'd5;
      5'd20:   kw_len = 4'd6;
      default: kw_len = 4'd0;
    endcase
  endfunction

  // Right-aligned keyword text, last character in the low byte
  function automatic logic [127:0] kw_word(input logic [4:0] k);
    unique case (k)
      5'd0:    kw_word = 128'("class");
      5'd1:    kw_word = 128'("constructor");
      5'd2:    kw_word = 128'("function");
      5'd3:    kw_word = 128'("method");
      5'd4:    kw_word = 128'("field");
      5'd5:    kw_word = 128'("static");
      5'd6:    kw_word = 128'("var");
      5'd7:    kw_word = 128'("int");
      5'd8:    kw_word = 128'("char");
      5'd9:    kw_word = 128'("boolean");
      5'd10:   kw_word = 128'("void");
      5'd11:   kw_word = 128'("true");
      5'd12:   kw_word = 128'("false");
      5'd13:   kw_word = 128'("null");
      5'd14:   kw_word = 128'("this");
      5'd15:   kw_word = 128'("let");
      5'd16:   kw_word = 128'("do");
      5'd17:   kw_word = 128'("if");
      5'd18:   kw_word = 128'("else");
      5'd19:   kw_word = 128'("while");
      5'd20:   kw_word = 128'("return");
      default: kw_word = '0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] i);
    logic [127:0] w;
    logic [3:0]   pos;
    w   = kw_word(k);
    pos = kw_len(k) - 4'd1 - i;
    kw_char = w[{pos, 3'b000} +: 8];
  endfunction

  function automatic logic [NUM_KW-1:0] match_kw(input logic [NUM_KW-1:0] cand,
                                                 input logic [POS_BITS:0] idx,
                                                 input logic [7:0] c);
    logic [NUM_KW-1:0] m;
    logic              near;
    m    = '0;
    near = (idx[POS_BITS:4] == '0);
    for (int k = 0; k < NUM_KW; k++) begin
      m[k] = cand[k] && near && (idx[3:0] < kw_len(5'(k)))
             && (kw_char(5'(k), idx[3:0]) == c);
    end
    return m;
  endfunction

endpackage

// ----- rtl/core/jl_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jl_in_if: source byte channel
// Valid/ready channel carrying one source byte or an end mark per transfer.
// ----------------------------------------------------------------------------
interface jl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       at_end;

  modport source (output valid, output ch, output at_end, input ready);
  modport sink   (input valid, input ch, input at_end, output ready);
endinterface

// ----- rtl/core/jl_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jl_out_if: token channel
// Valid/ready channel carrying one token per transfer.
// ----------------------------------------------------------------------------
interface jl_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   token_kind;
  logic [jl_pkg::POS_BITS-1:0]  token_start;
  logic [jl_pkg::POS_BITS:0]    token_length;
  logic [7:0]                   symbol_char;
  logic [4:0]                   keyword_number;
  logic                         last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output symbol_char, output keyword_number,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input symbol_char, input keyword_number,
                  input last_of_run, output ready);
endinterface

// ----- rtl/core/jl_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jl_scan: lexer state and single-pass token logic
// Holds mode, position, token start and keyword candidates; yields up to two
// tokens for the byte presented when step is high.
// ----------------------------------------------------------------------------
module jl_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            ch,
  input  logic                  at_end,
  output jl_pkg::scan_res_t     res
);

  localparam int PB = jl_pkg::POS_BITS;

  jl_pkg::mode_t               mode, mode_next;
  logic [PB:0]                 byte_position, byte_position_next;
  logic [PB-1:0]               token_begin, token_begin_next;
  logic [jl_pkg::NUM_KW-1:0]   keyword_candidates, keyword_candidates_next;

  logic                        is_end;
  logic [PB:0]                 span;
  logic [PB:0]                 p_inc;
  logic [PB-1:0]               p_sat, p_inc_sat;
  logic [4:0]                  word_kwn;
  logic                        pre_v, run_idle, idle_v;
  jl_pkg::token_t              pre_tok, idle_tok, first_tok, second_tok;
  jl_pkg::mode_t               idle_mode;
  logic                        idle_set_begin, idle_set_cand;
  logic [PB-1:0]               idle_begin;
  logic [1:0]                  count;

  assign is_end    = at_end || (ch == jl_pkg::CH_EOF);
  assign span      = (byte_position > {1'b0, token_begin})
                     ? byte_position - {1'b0, token_begin} : '0;
  assign p_inc     = byte_position + 1'b1;
  assign p_sat     = byte_position[PB] ? '1 : byte_position[PB-1:0];
  assign p_inc_sat = p_inc[PB] ? '1 : p_inc[PB-1:0];

  always_comb begin
    word_kwn = jl_pkg::NO_KEYWORD;
    for (int k = jl_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (keyword_candidates[k] && ({{(PB-3){1'b0}}, jl_pkg::kw_len(5'(k))} == span)) begin
        word_kwn = 5'(k);
      end
    end
  end

  // Token start handling from the between-tokens state
  always_comb begin
    idle_mode      = jl_pkg::MODE_IDLE;
    idle_set_begin = 1'b0;
    idle_set_cand  = 1'b0;
    idle_begin     = p_sat;
    idle_v         = 1'b0;
    idle_tok       = jl_pkg::make_tok(jl_pkg::KIND_END, '0, '0, 8'd0, jl_pkg::NO_KEYWORD);
    if (is_end) begin
      idle_v = 1'b1;
    end else if (ch == jl_pkg::CH_QUOTE) begin
      idle_set_begin = 1'b1;
      idle_begin     = p_inc_sat;
      idle_mode      = jl_pkg::MODE_STRING;
    end else if (jl_pkg::is_digit(ch)) begin
      idle_set_begin = 1'b1;
      idle_mode      = jl_pkg::MODE_INT;
    end else if (ch == jl_pkg::CH_SLASH) begin
      idle_set_begin = 1'b1;
      idle_mode      = jl_pkg::MODE_SLASH;
    end else if (jl_pkg::is_symbol(ch)) begin
      idle_set_begin = 1'b1;
      idle_v         = 1'b1;
      idle_tok       = jl_pkg::make_tok(jl_pkg::KIND_SYMBOL, p_sat, (PB+1)'(1), ch,
                                        jl_pkg::NO_KEYWORD);
    end else if (!jl_pkg::is_space(ch)) begin
      idle_set_begin = 1'b1;
      idle_set_cand  = 1'b1;
      idle_mode      = jl_pkg::MODE_IDENT;
    end
  end

  always_comb begin
    mode_next               = mode;
    keyword_candidates_next = keyword_candidates;
    pre_v                   = 1'b0;
    run_idle                = 1'b0;
    pre_tok                 = jl_pkg::make_tok(jl_pkg::KIND_SYMBOL, token_begin, (PB+1)'(1),
                                               jl_pkg::CH_SLASH, jl_pkg::NO_KEYWORD);
    unique case (mode) inside
      jl_pkg::MODE_IDLE: begin
        run_idle = 1'b1;
      end
      jl_pkg::MODE_SLASH: begin
        if (!is_end && ch == jl_pkg::CH_SLASH) begin
          mode_next = jl_pkg::MODE_LINE;
        end else if (!is_end && ch == jl_pkg::CH_STAR) begin
          mode_next = jl_pkg::MODE_BLOCK;
        end else begin
          pre_v    = 1'b1;
          run_idle = 1'b1;
        end
      end
      jl_pkg::MODE_LINE: begin
        if (is_end) begin
          run_idle = 1'b1;
        end else if (ch == jl_pkg::CH_NL) begin
          mode_next = jl_pkg::MODE_IDLE;
        end
      end
      jl_pkg::MODE_BLOCK, jl_pkg::MODE_BLOCKSTAR: begin
        if (is_end) begin
          run_idle = 1'b1;
        end else if (ch == jl_pkg::CH_STAR) begin
          mode_next = jl_pkg::MODE_BLOCKSTAR;
        end else if (ch == jl_pkg::CH_SLASH && mode == jl_pkg::MODE_BLOCKSTAR) begin
          mode_next = jl_pkg::MODE_IDLE;
        end else begin
          mode_next = jl_pkg::MODE_BLOCK;
        end
      end
      jl_pkg::MODE_IDENT: begin
        if (is_end || jl_pkg::is_space(ch) || jl_pkg::is_symbol(ch)) begin
          pre_v    = 1'b1;
          run_idle = 1'b1;
          keyword_candidates_next = '0;
          pre_tok  = jl_pkg::make_tok((word_kwn == jl_pkg::NO_KEYWORD)
                                      ? jl_pkg::KIND_IDENT : jl_pkg::KIND_KEYWORD,
                                      token_begin, span, 8'd0, word_kwn);
        end else begin
          keyword_candidates_next = jl_pkg::match_kw(keyword_candidates, span, ch);
        end
      end
      jl_pkg::MODE_STRING: begin
        if (is_end || ch == jl_pkg::CH_NL) begin
          pre_v     = 1'b1;
          mode_next = jl_pkg::MODE_IDLE;
          pre_tok   = jl_pkg::make_tok(jl_pkg::KIND_ERROR, token_begin, span, 8'd0,
                                       jl_pkg::NO_KEYWORD);
        end else if (ch == jl_pkg::CH_QUOTE) begin
          pre_v     = 1'b1;
          mode_next = jl_pkg::MODE_IDLE;
          pre_tok   = jl_pkg::make_tok(jl_pkg::KIND_STRING, token_begin, span, 8'd0,
                                       jl_pkg::NO_KEYWORD);
        end
      end
      jl_pkg::MODE_INT: begin
        if (is_end || !jl_pkg::is_digit(ch)) begin
          pre_v    = 1'b1;
          run_idle = 1'b1;
          pre_tok  = jl_pkg::make_tok(jl_pkg::KIND_INTEGER, token_begin, span, 8'd0,
                                      jl_pkg::NO_KEYWORD);
        end
      end
      default: begin
        mode_next = jl_pkg::MODE_IDLE;
      end
    endcase

    token_begin_next = token_begin;
    if (run_idle) begin
      mode_next = idle_mode;
      if (idle_set_begin) begin
        token_begin_next = idle_begin;
      end
      if (idle_set_cand) begin
        keyword_candidates_next = jl_pkg::match_kw('1, '0, ch);
      end
    end

    byte_position_next = byte_position;
    if (!at_end && !byte_position[PB]) begin
      byte_position_next = p_inc;
    end
  end

  always_comb begin
    count      = 2'(pre_v) + 2'(run_idle && idle_v);
    first_tok  = pre_v ? pre_tok : idle_tok;
    second_tok = idle_tok;
    first_tok.last  = (count == 2'd1);
    second_tok.last = 1'b1;
    res.count  = count;
    res.first  = first_tok;
    res.second = second_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= jl_pkg::MODE_IDLE;
      byte_position      <= '0;
      token_begin        <= '0;
      keyword_candidates <= '0;
    end else if (step) begin
      mode               <= mode_next;
      byte_position      <= byte_position_next;
      token_begin        <= token_begin_next;
      keyword_candidates <= keyword_candidates_next;
    end
  end

endmodule

// ----- rtl/core/jl_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jl_outq: two-entry token result register
// Holds the tokens of one scanned byte and hands them out one per transfer.
// ----------------------------------------------------------------------------
module jl_outq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  jl_pkg::scan_res_t     res,
  output logic                  space,
  jl_out_if.source              tokens
);

  logic [1:0]     count;
  jl_pkg::token_t slot0, slot1;
  logic           pop;

  assign pop   = (count != 2'd0) && tokens.ready;
  assign space = (count == 2'd0) || ((count == 2'd1) && tokens.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load && res.count != 2'd0) begin
      count <= res.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.count != 2'd0) begin
      slot0 <= res.first;
      slot1 <= res.second;
    end else if (pop && count == 2'd2) begin
      slot0 <= slot1;
    end
  end

  assign tokens.valid          = (count != 2'd0);
  assign tokens.token_kind     = slot0.kind;
  assign tokens.token_start    = slot0.start;
  assign tokens.token_length   = slot0.length;
  assign tokens.symbol_char    = slot0.sym;
  assign tokens.keyword_number = slot0.kwn;
  assign tokens.last_of_run    = slot0.last;

endmodule

// ----- rtl/core/jack_lexer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jack_lexer: streaming tokenizer for the Jack language
// Turns a byte stream into keyword, symbol, string, integer, identifier,
// error and end tokens, skipping whitespace and comments.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one source byte per transfer, or an end mark (at_end, or byte
//            0xFF). After an end the lexer starts afresh; offsets keep counting.
//   tokens : one token per transfer; last_of_run flags the final token caused
//            by a byte. A byte gives zero, one or two tokens.
//   Order:   a byte taken into the scan stage register is scanned into the
//            result register when it has space; tokens are offered from there.
//   Throughput: one byte per cycle while tokens.ready is high. A byte that
//            yields two tokens holds the next byte in the scan stage while
//            the second token drains from the two-entry result register.
//   Stalls: while tokens.ready is low the result register fills, the scan
//            stage holds its byte and text.ready falls; nothing is lost.
//   Reset (rst, synchronous): mode between tokens, offset zero, result
//            register empty.
// ----------------------------------------------------------------------------
module jack_lexer (
  input  logic         clk,
  input  logic         rst,
  jl_in_if.sink        text,
  jl_out_if.source     tokens
);

  logic              s1_valid;
  logic [7:0]        s1_ch;
  logic              s1_at_end;
  logic              space;
  logic              take;
  jl_pkg::scan_res_t res;

  assign take       = s1_valid && space;
  assign text.ready = !s1_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.valid && text.ready) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_ch     <= text.ch;
      s1_at_end <= text.at_end;
    end
  end

  jl_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (take),
    .ch     (s1_ch),
    .at_end (s1_at_end),
    .res    (res)
  );

  jl_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .load   (take),
    .res    (res),
    .space  (space),
    .tokens (tokens)
  );

  a_pair_offered: assert property (@(posedge clk) disable iff (rst)
    take && res.count == 2'd2 |=> tokens.valid && !tokens.last_of_run)
    else $error("first of a token pair not offered");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !space |=> s1_valid && $stable(s1_ch) && $stable(s1_at_end))
    else $error("scan stage lost a waiting byte");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.token_kind == jl_pkg::KIND_END |-> tokens.last_of_run)
    else $error("end token not last of its run");

  a_symbol_len: assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.token_kind == jl_pkg::KIND_SYMBOL
    |-> tokens.token_length == (jl_pkg::POS_BITS+1)'(1))
    else $error("symbol token length not one");

endmodule

// ----- tb/sv/jack_lexer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jack_lexer_tb: self-checking bench for the streaming Jack tokenizer
// Feeds bytes and end marks through the text channel and predicts every
// token in a behavioural lexer of its own. It then checks each token transfer
// against the oldest prediction. Directed text covers the edge cases, then
// the keyword table and a long receiver hold-off are run, then random Jack-like
// source with noise. Sender bursts and receiver stalls vary throughout.
// ----------------------------------------------------------------------------
module jack_lexer_tb;
  import jl_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 8;
  localparam int ITEMS_RANDOM = 1350;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;
  localparam int TIMEOUT_NS   = 6_000_000;

  localparam logic [POS_BITS:0]   POS_LIMIT = {1'b1, {POS_BITS{1'b0}}};
  localparam logic [POS_BITS+1:0] BEGIN_TOP = {2'b00, {POS_BITS{1'b1}}};

  localparam int STALL_NONE   = 0;
  localparam int STALL_LIGHT  = 1;
  localparam int STALL_PERIOD = 2;
  localparam int STALL_HEAVY  = 3;

  logic clk = 1'b0;
  logic rst;

  jl_in_if  text_if ();
  jl_out_if token_if ();

  jack_lexer u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if),
    .tokens (token_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  string kw_names[NUM_KW] = '{
    "class", "constructor", "function", "method", "field", "static", "var",
    "int", "char", "boolean", "void", "true", "false", "null", "this", "let",
    "do", "if", "else", "while", "return"
  };
  string punct_set = "{}()[].,;+-*&|<>=~";
  string blank_set = " \t\n\r";
  string block_set = "ab */*";

  // lexer state of the predictor
  mode_t               lex_mode;
  logic [POS_BITS:0]   lex_pos;
  logic [POS_BITS-1:0] lex_begin;
  logic [NUM_KW-1:0]   kw_live;

  token_t token_q[$];

  int items_sent;
  int bytes_sent;
  int ends_sent;
  int tokens_seen;
  int error_count;
  int kind_seen[8];
  int burst_left;
  int hold_req;

  // --------------------------------------------------------------------------
  // token prediction
  // --------------------------------------------------------------------------
  function automatic logic is_gap(input logic [7:0] c);
    for (int i = 0; i < blank_set.len(); i++)
      if (blank_set[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    for (int i = 0; i < punct_set.len(); i++)
      if (punct_set[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void mark_begin(input logic [POS_BITS+1:0] p);
    lex_begin = (p > BEGIN_TOP) ? BEGIN_TOP[POS_BITS-1:0] : p[POS_BITS-1:0];
  endfunction

  function automatic logic [POS_BITS:0] span_to(input logic [POS_BITS:0] p);
    return (p > {1'b0, lex_begin}) ? p - {1'b0, lex_begin} : '0;
  endfunction

  function automatic logic [NUM_KW-1:0] narrow_keywords(input logic [NUM_KW-1:0] cand,
                                                        input logic [POS_BITS:0] idx,
                                                        input logic [7:0] c);
    logic [NUM_KW-1:0] keep;
    keep = '0;
    for (int k = 0; k < NUM_KW; k++)
      if (cand[k] && idx < kw_names[k].len())
        if (kw_names[k][idx] == c) keep[k] = 1'b1;
    return keep;
  endfunction

  function automatic void add_token(input logic [2:0] kind, input logic [POS_BITS-1:0] start,
                                    input logic [POS_BITS:0] len, input logic [7:0] sym,
                                    input logic [4:0] kwn);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.sym    = sym;
    t.kwn    = kwn;
    t.last   = 1'b0;
    token_q.push_back(t);
  endfunction

  function automatic void close_word(input logic [POS_BITS:0] p);
    logic [POS_BITS:0] len;
    logic [4:0]        kwn;
    len = span_to(p);
    kwn = NO_KEYWORD;
    for (int k = NUM_KW - 1; k >= 0; k--)
      if (kw_live[k] && kw_names[k].len() == len) kwn = 5'(k);
    add_token((kwn == NO_KEYWORD) ? KIND_IDENT : KIND_KEYWORD, lex_begin, len, 8'h00, kwn);
  endfunction

  function automatic void start_token(input logic [7:0] c, input logic is_end,
                                      input logic [POS_BITS:0] p);
    lex_mode = MODE_IDLE;
    if (is_end) begin
      add_token(KIND_END, '0, '0, 8'h00, NO_KEYWORD);
    end else if (c == CH_QUOTE) begin
      mark_begin({1'b0, p} + (POS_BITS+2)'(1));
      lex_mode = MODE_STRING;
    end else if (is_numeral(c)) begin
      mark_begin({1'b0, p});
      lex_mode = MODE_INT;
    end else if (c == CH_SLASH) begin
      mark_begin({1'b0, p});
      lex_mode = MODE_SLASH;
    end else if (is_punct(c)) begin
      mark_begin({1'b0, p});
      add_token(KIND_SYMBOL, lex_begin, (POS_BITS+1)'(1), c, NO_KEYWORD);
    end else if (!is_gap(c)) begin
      mark_begin({1'b0, p});
      lex_mode = MODE_IDENT;
      kw_live  = narrow_keywords('1, '0, c);
    end
  endfunction

  function automatic void lex_step(input logic [7:0] c, input logic end_mark);
    logic              e;
    logic [POS_BITS:0] p;
    int                n0;
    token_t            t;
    e  = end_mark || c == CH_EOF;
    p  = lex_pos;
    n0 = token_q.size();
    case (lex_mode) inside
      MODE_IDLE: begin
        start_token(c, e, p);
      end
      MODE_SLASH: begin
        if (!e && c == CH_SLASH) lex_mode = MODE_LINE;
        else if (!e && c == CH_STAR) lex_mode = MODE_BLOCK;
        else begin
          add_token(KIND_SYMBOL, lex_begin, (POS_BITS+1)'(1), CH_SLASH, NO_KEYWORD);
          start_token(c, e, p);
        end
      end
      MODE_LINE: begin
        if (e) start_token(c, 1'b1, p);
        else if (c == CH_NL) lex_mode = MODE_IDLE;
      end
      MODE_BLOCK, MODE_BLOCKSTAR: begin
        if (e) start_token(c, 1'b1, p);
        else if (c == CH_STAR) lex_mode = MODE_BLOCKSTAR;
        else if (c == CH_SLASH && lex_mode == MODE_BLOCKSTAR) lex_mode = MODE_IDLE;
        else lex_mode = MODE_BLOCK;
      end
      MODE_IDENT: begin
        if (e || is_gap(c) || is_punct(c)) begin
          close_word(p);
          kw_live = '0;
          start_token(c, e, p);
        end else begin
          kw_live = narrow_keywords(kw_live, span_to(p), c);
        end
      end
      MODE_STRING: begin
        if (e || c == CH_NL) begin
          add_token(KIND_ERROR, lex_begin, span_to(p), 8'h00, NO_KEYWORD);
          lex_mode = MODE_IDLE;
        end else if (c == CH_QUOTE) begin
          add_token(KIND_STRING, lex_begin, span_to(p), 8'h00, NO_KEYWORD);
          lex_mode = MODE_IDLE;
        end
      end
      default: begin
        if (e || !is_numeral(c)) begin
          add_token(KIND_INTEGER, lex_begin, span_to(p), 8'h00, NO_KEYWORD);
          start_token(c, e, p);
        end
      end
    endcase
    if (!end_mark && lex_pos < POS_LIMIT) lex_pos = lex_pos + 1'b1;
    if (token_q.size() > n0) begin
      t      = token_q.pop_back();
      t.last = 1'b1;
      token_q.push_back(t);
    end
  endfunction

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic end_mark);
    text_if.valid  <= 1'b1;
    text_if.ch     <= c;
    text_if.at_end <= end_mark;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    lex_step(c, end_mark);
    items_sent++;
    if (end_mark) ends_sent++;
    else bytes_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(0, 20);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // random source text
  // --------------------------------------------------------------------------
  function automatic logic [7:0] word_byte(input logic first);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 80) return 8'($urandom_range(8'h41, 8'h5A));
    if (r < 85) return 8'h5F;
    if (first) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 91) return 8'($urandom_range(8'h30, 8'h39));
    if (r < 94) return CH_SLASH;
    if (r < 96) return CH_QUOTE;
    return 8'($urandom_range(8'h80, 8'hFE));
  endfunction

  function automatic logic [7:0] quoted_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(8'h80, 8'hFE));
    b = 8'($urandom_range(8'h20, 8'h7E));
    return (b == CH_QUOTE) ? 8'h71 : b;
  endfunction

  task automatic emit_random_piece();
    int         r;
    int         n;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      n = $urandom_range(0, NUM_KW - 1);
      if (r < 4) send_text(kw_names[n].substr(0, kw_names[n].len() - 2));
      else send_text(kw_names[n]);
      if (r == 4) send_byte(word_byte(1'b0), 1'b0);
    end else if (r < 35) begin
      send_byte(word_byte(1'b1), 1'b0);
      repeat ($urandom_range(0, 7)) send_byte(word_byte(1'b0), 1'b0);
    end else if (r < 45) begin
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(8'h30, 8'h39)), 1'b0);
    end else if (r < 53) begin
      send_byte(CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 6)) send_byte(quoted_byte(), 1'b0);
      n = $urandom_range(0, 19);
      if (n == 0) send_byte(CH_NL, 1'b0);
      else if (n == 1) send_end();
      else send_byte(CH_QUOTE, 1'b0);
    end else if (r < 67) begin
      send_byte(punct_set[$urandom_range(0, punct_set.len() - 1)], 1'b0);
    end else if (r < 77) begin
      repeat ($urandom_range(1, 3)) send_byte(blank_set[$urandom_range(0, 3)], 1'b0);
    end else if (r < 81) begin
      send_text("//");
      repeat ($urandom_range(0, 8)) begin
        b = 8'($urandom_range(0, 254));
        send_byte((b == CH_NL) ? 8'h20 : b, 1'b0);
      end
      send_byte(CH_NL, 1'b0);
    end else if (r < 85) begin
      send_text("/*");
      repeat ($urandom_range(0, 8))
        send_byte(block_set[$urandom_range(0, block_set.len() - 1)], 1'b0);
      send_text("*/");
    end else if (r < 88) begin
      send_byte(CH_SLASH, 1'b0);
    end else if (r < 91) begin
      if ($urandom_range(0, 1) == 0) send_end();
      else send_byte(CH_EOF, 1'b0);
    end else begin
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_edge_cases();
    // keyword, identifier with slash, quote and digit, then symbol
    send_text("do a/\"9{ 12");
    // integer closed by the 0xFF byte
    send_byte(CH_EOF, 1'b0);
    // lone slash closed by the end mark
    send_text("/");
    send_end();
    // newline inside a string, then a string cut off by the end mark
    send_text("\"x\n\"y");
    send_end();
    // lone slash before a symbol, keyword closed by the end mark
    send_text("/;if");
    send_end();
  endtask

  task automatic test_keyword_table();
    for (int k = 0; k < NUM_KW; k++) begin
      send_text(kw_names[k]);
      if (k % 2 == 0) send_byte(8'h20, 1'b0);
      else send_byte(punct_set[$urandom_range(0, punct_set.len() - 1)], 1'b0);
    end
    send_text("clas whiles(retur;d\tconstructors ");
  endtask

  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    repeat (60) send_byte(punct_set[$urandom_range(0, punct_set.len() - 1)], 1'b0);
    send_text("let x = 42; ");
  endtask

  task automatic test_random_source();
    int stop_at;
    stop_at = items_sent + ITEMS_RANDOM;
    while (items_sent < stop_at) emit_random_piece();
    send_end();
  endtask

  // --------------------------------------------------------------------------
  // receiver: stall pattern and long hold-off
  // --------------------------------------------------------------------------
  initial begin : token_sink
    int style;
    int style_left;
    int hold_left;
    int phase;
    style      = STALL_NONE;
    style_left = 0;
    hold_left  = 0;
    phase      = 0;
    token_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (style_left == 0) begin
        style      = $urandom_range(STALL_NONE, STALL_HEAVY);
        style_left = $urandom_range(20, 200);
      end
      style_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        token_if.ready <= 1'b0;
      end else begin
        case (style)
          STALL_NONE:   token_if.ready <= 1'b1;
          STALL_LIGHT:  token_if.ready <= ($urandom_range(0, 9) < 7);
          STALL_PERIOD: token_if.ready <= (phase % 5 >= 2);
          default:      token_if.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // token check
  // --------------------------------------------------------------------------
  function automatic string tok_text(input token_t t);
    return $sformatf("kind=%0d start=%0d len=%0d sym=%02h kw=%0d last=%0b",
                     t.kind, t.start, t.length, t.sym, t.kwn, t.last);
  endfunction

  function automatic void report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : check_tokens
    token_t got;
    token_t want;
    if (!rst && token_if.valid && token_if.ready) begin
      got.kind   = token_if.token_kind;
      got.start  = token_if.token_start;
      got.length = token_if.token_length;
      got.sym    = token_if.symbol_char;
      got.kwn    = token_if.keyword_number;
      got.last   = token_if.last_of_run;
      tokens_seen++;
      kind_seen[got.kind]++;
      if (token_q.size() == 0) begin
        report_error({"unexpected token ", tok_text(got)});
      end else begin
        want = token_q.pop_front();
        if (got.kind != want.kind || got.start != want.start || got.length != want.length
            || got.sym != want.sym || got.kwn != want.kwn || got.last != want.last)
          report_error($sformatf("token %0d: expected %s, got %s",
                                 tokens_seen, tok_text(want), tok_text(got)));
      end
    end
  end

  // --------------------------------------------------------------------------
  // run control
  // --------------------------------------------------------------------------
  initial begin
    #(TIMEOUT_NS);
    $display("jack_lexer_tb: done, errors");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    text_if.valid  = 1'b0;
    text_if.ch     = 8'h00;
    text_if.at_end = 1'b0;
    lex_mode       = MODE_IDLE;
    lex_pos        = '0;
    lex_begin      = '0;
    kw_live        = '0;
    items_sent     = 0;
    bytes_sent     = 0;
    ends_sent      = 0;
    tokens_seen    = 0;
    error_count    = 0;
    burst_left     = 0;
    hold_req       = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_edge_cases();
    test_keyword_table();
    test_backpressure();
    test_random_source();

    text_if.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d bytes and %0d end marks sent, %0d tokens checked, %0d mismatches",
             bytes_sent, ends_sent, tokens_seen, error_count);
    $display("summary: keyword %0d symbol %0d string %0d integer %0d ident %0d error %0d end %0d",
             kind_seen[KIND_KEYWORD], kind_seen[KIND_SYMBOL], kind_seen[KIND_STRING],
             kind_seen[KIND_INTEGER], kind_seen[KIND_IDENT], kind_seen[KIND_ERROR],
             kind_seen[KIND_END]);
    if (error_count == 0) begin
      $display("jack_lexer_tb: done, clean");
    end else begin
      $display("jack_lexer_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/jl_pkg.sv
rtl/core/jl_in_if.sv
rtl/core/jl_out_if.sv
rtl/core/jl_scan.sv
rtl/core/jl_outq.sv
rtl/core/jack_lexer.sv
tb/sv/jack_lexer_tb.sv
